/* rtl/m4inv_pkg.sv */
// Shared constants, types and index helpers for the 4x4 adjugate inverse.
// Used by matrix4_adjugate_inverse; depends on nothing else.
package m4inv_pkg;

   // element format
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;

   // derived widths
   localparam int PROD_W = 2 * ELEM_W + 1;   // shared multiplier product
   localparam int COF_W  = 3 * ELEM_W + 1;   // signed 3x3 minor
   localparam int DET_W  = 4 * ELEM_W + 2;   // signed determinant
   localparam int QUO_W  = ELEM_W + 1;       // quotient bits before overflow
   localparam int QCNT_W = $clog2(QUO_W);
   localparam int WIDE_A = 5 * ELEM_W + 3;
   localparam int WIDE_B = 3 * ELEM_W + 2 * FRAC_BITS + 2;
   localparam int WIDE_W = (WIDE_A > WIDE_B) ? WIDE_A : WIDE_B;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_TERM,
      ST_WB,
      ST_DET,
      ST_DFIN,
      ST_QRD,
      ST_QSET,
      ST_QCHK,
      ST_QDIV,
      ST_PUT
   } state_type;

   // accumulator alignment of a partial product, in limbs of ELEM_W bits
   typedef enum logic [1:0] {
      SH_NONE,
      SH_ONE,
      SH_TWO
   } shift_type;

   // column picked in minor row n by permutation t of three
   function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] n);
      logic [5:0] p;
      begin
         case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            3'd5:    p = {2'd0, 2'd1, 2'd2};
            default: p = {2'd2, 2'd1, 2'd0};
         endcase
         case (n)
            2'd0:    perm_col = p[1:0];
            2'd1:    perm_col = p[3:2];
            default: perm_col = p[5:4];
         endcase
      end
   endfunction

   // store address of factor n of term t in the minor of entry (i, j)
   function automatic logic [3:0] term_addr(input logic [1:0] i, input logic [1:0] j,
                                            input logic [2:0] t, input logic [1:0] n);
      logic [1:0] sc;
      logic [1:0] row;
      logic [1:0] col;
      begin
         sc  = perm_col(t, n);
         row = (n < i) ? n : 2'(n + 2'd1);
         col = (sc < j) ? sc : 2'(sc + 2'd1);
         term_addr = {row, col};
      end
   endfunction

   // sign of term t, folded with the cofactor checkerboard sign
   function automatic logic term_neg(input logic [2:0] t, input logic [1:0] i,
                                     input logic [1:0] j);
      logic odd;
      begin
         case (t)
            3'd1, 3'd2, 3'd5: odd = 1'b1;
            default:          odd = 1'b0;
         endcase
         term_neg = odd ^ i[0] ^ j[0];
      end
   endfunction

endpackage

/* rtl/matrix4_adjugate_inverse.sv */
// 4x4 matrix inverse by adjugate over signed fixed point, element and cofactor stores.
// Depends on m4inv_pkg (widths, sequencer states, minor index helpers).
//
//   channel | direction | words          | content
//   req     | in        | 16 per matrix  | element_value, start_of_matrix
//   rsp     | out       | 16 per matrix  | inverse_value, element_index, singular,
//           |           |                | saturated, last_element
//
// Elements load at one word per cycle. After the sixteenth, input stalls while one
// shared 33x32 multiplier forms 96 triple products, stores 16 cofactors, then the
// determinant; each result then takes a 33-step restoring divider, which is skipped
// when singular or on quotient overflow. Reset (synchronous) returns to loading with
// no partial matrix. A stalled result holds and delays the next result by the stall;
// the next matrix may load while the last waits.
module matrix4_adjugate_inverse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [m4inv_pkg::ELEM_W-1:0]   req_element_value,
   input  logic                                  req_start_of_matrix,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [m4inv_pkg::ELEM_W-1:0]   rsp_inverse_value,
   output logic [3:0]                            rsp_element_index,
   output logic                                  rsp_singular,
   output logic                                  rsp_saturated,
   output logic                                  rsp_last_element
);
   import m4inv_pkg::*;

   // sequencer and counters
   state_type               state_ff, state_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [3:0]              idx_ff, idx_in;
   logic [2:0]              term_ff, term_in;
   logic [2:0]              sub_ff, sub_in;
   logic [QCNT_W-1:0]       qcnt_ff, qcnt_in;

   // operand holding
   logic signed [ELEM_W-1:0] e1_ff, e1_in;
   logic signed [ELEM_W-1:0] e3_ff, e3_in;
   logic [2*ELEM_W-1:0]      p_ff, p_in;
   logic [COF_W-1:0]         cw_ff, cw_in;

   // shared multiplier and accumulator
   logic signed [ELEM_W:0]   mul_a;
   logic signed [ELEM_W-1:0] mul_b;
   logic                     mul_add;
   logic                     mul_neg;
   shift_type                mul_sh;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     add_go_ff;
   logic                     add_neg_ff;
   shift_type                add_sh_ff;
   logic signed [DET_W-1:0]  add_ext, add_term;
   logic signed [DET_W-1:0]  acc_ff, acc_in;

   // determinant summary and divider
   logic                     det_neg_ff, det_neg_in;
   logic                     det_zero_ff, det_zero_in;
   logic [DET_W-1:0]         det_mag_ff, det_mag_in;
   logic [COF_W-1:0]         cof_mag;
   logic [WIDE_W-1:0]        rem_ff, rem_in;
   logic [WIDE_W-1:0]        dsh_ff, dsh_in;
   logic [QUO_W-1:0]         quot_ff, quot_in;
   logic                     qneg_ff, qneg_in;
   logic                     high_ff, high_in;
   logic                     div_ge;

   // result formatting
   logic                     res_neg;
   logic [ELEM_W-1:0]        res_value;
   logic                     res_sat;
   logic                     rsp_load;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]        rsp_value_ff;
   logic [3:0]               rsp_index_ff;
   logic                     rsp_sing_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_last_ff;

   // memories
   logic [ELEM_W-1:0]        elem_mem [16];
   logic signed [ELEM_W-1:0] elem_rd_ff;
   logic                     elem_we;
   logic [3:0]               elem_wa;
   logic [3:0]               elem_ra;
   logic [COF_W-1:0]         cof_mem [16];
   logic [COF_W-1:0]         cof_rd_ff;
   logic                     cof_we;
   logic [3:0]               cof_ra;

   // element store: written on load, read during minor expansion and for the determinant
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wa] <= req_element_value;
      end
      elem_rd_ff <= elem_mem[elem_ra];
   end

   // cofactor store: written per cofactor, read for determinant and division
   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_mem[idx_ff] <= acc_ff[COF_W-1:0];
      end
      cof_rd_ff <= cof_mem[cof_ra];
   end

   // align and sign the registered product for accumulation
   always_comb begin
      case (add_sh_ff)
         SH_NONE: add_ext = DET_W'(prod_ff);
         SH_ONE:  add_ext = DET_W'(prod_ff) <<< ELEM_W;
         SH_TWO:  add_ext = DET_W'(prod_ff) <<< (2 * ELEM_W);
         default: add_ext = DET_W'(prod_ff);
      endcase
      add_term = add_neg_ff ? -add_ext : add_ext;
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign cof_mag = cof_rd_ff[COF_W-1] ? COF_W'(-cof_rd_ff) : cof_rd_ff;
   assign div_ge  = (rem_ff >= dsh_ff);

   // round-and-clip of the finished quotient
   always_comb begin
      res_neg = qneg_ff && (high_ff || (quot_ff != '0));
      if (det_zero_ff) begin
         res_value = '0;
         res_sat   = 1'b0;
      end else if (res_neg) begin
         if (high_ff || (quot_ff > {2'b01, {(ELEM_W-1){1'b0}}})) begin
            res_value = {1'b1, {(ELEM_W-1){1'b0}}};
            res_sat   = 1'b1;
         end else begin
            res_value = ELEM_W'(0) - quot_ff[ELEM_W-1:0];
            res_sat   = 1'b0;
         end
      end else begin
         if (high_ff || (quot_ff[QUO_W-1:ELEM_W-1] != '0)) begin
            res_value = {1'b0, {(ELEM_W-1){1'b1}}};
            res_sat   = 1'b1;
         end else begin
            res_value = quot_ff[ELEM_W-1:0];
            res_sat   = 1'b0;
         end
      end
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      sub_in       = sub_ff;
      qcnt_in      = qcnt_ff;
      e1_in        = e1_ff;
      e3_in        = e3_ff;
      p_in         = p_ff;
      cw_in        = cw_ff;
      acc_in       = add_go_ff ? (acc_ff + add_term) : acc_ff;
      det_neg_in   = det_neg_ff;
      det_zero_in  = det_zero_ff;
      det_mag_in   = det_mag_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      qneg_in      = qneg_ff;
      high_in      = high_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_add      = 1'b0;
      mul_neg      = 1'b0;
      mul_sh       = SH_NONE;
      elem_we      = 1'b0;
      elem_wa      = req_start_of_matrix ? 4'd0 : cnt_ff;
      elem_ra      = '0;
      cof_we       = 1'b0;
      cof_ra       = '0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         // take elements; the sixteenth starts the expansion
         ST_LOAD: begin
            if (req_valid) begin
               elem_we = 1'b1;
               if (elem_wa == 4'd15) begin
                  cnt_in   = '0;
                  idx_in   = '0;
                  term_in  = '0;
                  sub_in   = '0;
                  acc_in   = '0;
                  state_in = ST_TERM;
               end else begin
                  cnt_in = 4'(elem_wa + 4'd1);
               end
            end
         end

         // one triple product of a 3x3 minor
         ST_TERM: begin
            elem_ra = term_addr(idx_ff[3:2], idx_ff[1:0], term_ff, sub_ff[1:0]);
            sub_in  = 3'(sub_ff + 3'd1);
            case (sub_ff)
               3'd1: e1_in = elem_rd_ff;
               3'd2: begin
                  mul_a = (ELEM_W+1)'(e1_ff);
                  mul_b = elem_rd_ff;
               end
               3'd3: begin
                  e3_in = elem_rd_ff;
                  p_in  = prod_ff[2*ELEM_W-1:0];
               end
               3'd4: begin
                  mul_a   = {1'b0, p_ff[ELEM_W-1:0]};
                  mul_b   = e3_ff;
                  mul_add = 1'b1;
                  mul_neg = term_neg(term_ff, idx_ff[3:2], idx_ff[1:0]);
                  mul_sh  = SH_NONE;
               end
               3'd5: begin
                  mul_a   = (ELEM_W+1)'($signed(p_ff[2*ELEM_W-1:ELEM_W]));
                  mul_b   = e3_ff;
                  mul_add = 1'b1;
                  mul_neg = term_neg(term_ff, idx_ff[3:2], idx_ff[1:0]);
                  mul_sh  = SH_ONE;
               end
               3'd6: begin
                  sub_in = '0;
                  if (term_ff == 3'd5) begin
                     term_in  = '0;
                     state_in = ST_WB;
                  end else begin
                     term_in = 3'(term_ff + 3'd1);
                  end
               end
               default: ;
            endcase
         end

         // store the finished cofactor and clear for the next
         ST_WB: begin
            cof_we = 1'b1;
            acc_in = '0;
            sub_in = '0;
            if (idx_ff == 4'd15) begin
               idx_in   = '0;
               state_in = ST_DET;
            end else begin
               idx_in   = 4'(idx_ff + 4'd1);
               state_in = ST_TERM;
            end
         end

         // determinant along the first row, cofactor limb by limb
         ST_DET: begin
            elem_ra = {2'b00, idx_ff[1:0]};
            cof_ra  = {2'b00, idx_ff[1:0]};
            sub_in  = 3'(sub_ff + 3'd1);
            case (sub_ff)
               3'd1: begin
                  e3_in = elem_rd_ff;
                  cw_in = cof_rd_ff;
               end
               3'd2: begin
                  mul_a   = {1'b0, cw_ff[ELEM_W-1:0]};
                  mul_b   = e3_ff;
                  mul_add = 1'b1;
                  mul_sh  = SH_NONE;
               end
               3'd3: begin
                  mul_a   = {1'b0, cw_ff[2*ELEM_W-1:ELEM_W]};
                  mul_b   = e3_ff;
                  mul_add = 1'b1;
                  mul_sh  = SH_ONE;
               end
               3'd4: begin
                  mul_a   = $signed(cw_ff[COF_W-1:2*ELEM_W]);
                  mul_b   = e3_ff;
                  mul_add = 1'b1;
                  mul_sh  = SH_TWO;
               end
               3'd5: begin
                  sub_in = '0;
                  if (idx_ff[1:0] == 2'd3) begin
                     state_in = ST_DFIN;
                  end else begin
                     idx_in = 4'(idx_ff + 4'd1);
                  end
               end
               default: ;
            endcase
         end

         // capture sign, magnitude and zero test of the determinant
         ST_DFIN: begin
            det_neg_in  = acc_ff[DET_W-1];
            det_zero_in = (acc_ff == '0);
            det_mag_in  = acc_ff[DET_W-1] ? DET_W'(-acc_ff) : DET_W'(acc_ff);
            idx_in      = '0;
            state_in    = ST_QRD;
         end

         // fetch the transposed cofactor for this result
         ST_QRD: begin
            cof_ra   = {idx_ff[1:0], idx_ff[3:2]};
            state_in = ST_QSET;
         end

         // form the rounding numerator and the aligned divisor
         ST_QSET: begin
            if (det_zero_ff) begin
               state_in = ST_PUT;
            end else begin
               rem_in   = (WIDE_W'(cof_mag) << (2 * FRAC_BITS + 1)) + WIDE_W'(det_mag_ff);
               dsh_in   = WIDE_W'(det_mag_ff) << QUO_W;
               qneg_in  = cof_rd_ff[COF_W-1] ^ det_neg_ff;
               state_in = ST_QCHK;
            end
         end

         // flag a quotient too large for the divider
         ST_QCHK: begin
            high_in  = (rem_ff >= (dsh_ff << 1));
            quot_in  = '0;
            qcnt_in  = QCNT_W'(QUO_W - 1);
            state_in = high_in ? ST_PUT : ST_QDIV;
         end

         // restoring division, one quotient bit per cycle
         ST_QDIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quot_in = {quot_ff[QUO_W-2:0], div_ge};
            dsh_in  = dsh_ff >> 1;
            qcnt_in = QCNT_W'(qcnt_ff - 1'b1);
            if (qcnt_ff == '0) begin
               state_in = ST_PUT;
            end
         end

         // hand the word to the output register when it is free
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (idx_ff == 4'd15) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = 4'(idx_ff + 4'd1);
                  state_in = ST_QRD;
               end
            end
         end

         default: state_in = ST_LOAD;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         add_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         add_go_ff    <= mul_add;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      term_ff     <= term_in;
      sub_ff      <= sub_in;
      qcnt_ff     <= qcnt_in;
      e1_ff       <= e1_in;
      e3_ff       <= e3_in;
      p_ff        <= p_in;
      cw_ff       <= cw_in;
      prod_ff     <= prod_in;
      add_neg_ff  <= mul_neg;
      add_sh_ff   <= mul_sh;
      acc_ff      <= acc_in;
      det_neg_ff  <= det_neg_in;
      det_zero_ff <= det_zero_in;
      det_mag_ff  <= det_mag_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
      qneg_ff     <= qneg_in;
      high_ff     <= high_in;
      if (rsp_load) begin
         rsp_value_ff <= res_value;
         rsp_index_ff <= idx_ff;
         rsp_sing_ff  <= det_zero_ff;
         rsp_sat_ff   <= res_sat;
         rsp_last_ff  <= (idx_ff == 4'd15);
      end
   end

   assign req_stall         = (state_ff != ST_LOAD);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inverse_value = $signed(rsp_value_ff);
   assign rsp_element_index = rsp_index_ff;
   assign rsp_singular      = rsp_sing_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_last_element  = rsp_last_ff;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for matrix4_adjugate_inverse: drives matrix words, predicts
// each inverse exactly in wide integer arithmetic and checks every result word.
// Depends on m4inv_pkg and the matrix4_adjugate_inverse RTL.
`timescale 1ns / 1ps

module tb_top;
   import m4inv_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [ELEM_W-1:0] value;
      logic                     start;
      logic                     drain;   // hold off until all results are back
   } req_word_type;

   typedef struct {
      logic signed [ELEM_W-1:0] value;
      logic [3:0]               index;
      logic                     singular;
      logic                     saturated;
      logic                     last;
   } inv_word_type;

   typedef enum int {
      MX_IDENTITY, MX_TINY_DIAG, MX_ZERO, MX_EXTREME,
      MX_DOMINANT, MX_FULL_RANDOM, MX_DUP_ROW
   } matrix_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_element_value;
   logic                     req_start_of_matrix;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [ELEM_W-1:0] rsp_inverse_value;
   logic [3:0]               rsp_element_index;
   logic                     rsp_singular;
   logic                     rsp_saturated;
   logic                     rsp_last_element;

   req_word_type pending_words[$];
   inv_word_type expected_inverse[$];
   wide_type     held_elems[16];
   int           held_count;
   int           error_count;
   int           words_sent;
   int           results_seen;
   int           singular_seen;
   int           saturated_seen;
   int           send_gap;
   int           stall_left;
   int           hold_left;
   bit           long_hold_done;
   bit           req_took;

   matrix4_adjugate_inverse i_dut (.*);

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      begin
         r = $urandom_range(0, 99);
         if (r < 55) pick_gap = 0;
         else if (r < 92) pick_gap = $urandom_range(1, 3);
         else pick_gap = $urandom_range(20, 70);
      end
   endfunction

   // signed cofactor of entry (i, j) from the held elements
   function automatic wide_type cofactor_at(input int i, input int j);
      int       rr[3], cc[3], n;
      wide_type a[3][3];
      wide_type d;
      begin
         n = 0;
         for (int k = 0; k < 4; k++) if (k != i) begin rr[n] = k; n++; end
         n = 0;
         for (int k = 0; k < 4; k++) if (k != j) begin cc[n] = k; n++; end
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               a[r][c] = held_elems[rr[r] * 4 + cc[c]];
         d = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
           - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
           + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
         cofactor_at = ((i + j) % 2 == 1) ? -d : d;
      end
   endfunction

   // load one element; on the sixteenth, queue the sixteen inverse words
   task automatic load_element(input logic signed [ELEM_W-1:0] value, input logic start);
      wide_type     cof[4][4];
      wide_type     det, num, abs_num, abs_det, quot;
      wide_type     pos_limit;
      logic         neg;
      inv_word_type w;
      begin
         if (start || held_count >= 16) held_count = 0;
         held_elems[held_count] = wide_type'(value);
         held_count++;
         if (held_count == 16) begin
            held_count = 0;
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++)
                  cof[r][c] = cofactor_at(r, c);
            det = 0;
            for (int c = 0; c < 4; c++) det = det + held_elems[c] * cof[0][c];
            abs_det   = (det < 0) ? -det : det;
            pos_limit = (wide_type'(1) <<< (ELEM_W - 1)) - 1;
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) begin
                  w.index     = 4'(r * 4 + c);
                  w.singular  = (det == 0);
                  w.saturated = 1'b0;
                  w.last      = (r == 3 && c == 3);
                  w.value     = '0;
                  if (det != 0) begin
                     num     = cof[c][r] <<< (2 * FRAC_BITS);
                     neg     = (num < 0) != (det < 0);
                     abs_num = (num < 0) ? -num : num;
                     quot    = (2 * abs_num + abs_det) / (2 * abs_det);
                     if (quot == 0) neg = 1'b0;
                     if (neg) begin
                        if (quot > pos_limit + 1) begin
                           quot = pos_limit + 1;
                           w.saturated = 1'b1;
                        end
                        w.value = ELEM_W'(-quot);
                     end else begin
                        if (quot > pos_limit) begin
                           quot = pos_limit;
                           w.saturated = 1'b1;
                        end
                        w.value = ELEM_W'(quot);
                     end
                  end
                  expected_inverse.push_back(w);
               end
         end
      end
   endtask

   task automatic queue_word(input logic [ELEM_W-1:0] value, input logic start,
                             input logic drain);
      req_word_type w;
      begin
         w.value = value;
         w.start = start;
         w.drain = drain;
         pending_words.push_back(w);
      end
   endtask

   function automatic logic [ELEM_W-1:0] pick_element(input matrix_kind_type kind,
                                                       input int k);
      int r;
      begin
         r = k / 4;
         case (kind)
            MX_IDENTITY:  pick_element = (r == k % 4) ? 32'h0001_0000 : 32'h0;
            MX_TINY_DIAG: pick_element = (r == k % 4) ? ((k == 0) ? 32'hFFFF_FFFF : 32'h1)
                                                      : 32'h0;
            MX_ZERO:      pick_element = 32'h0;
            MX_EXTREME: begin
               if (r == k % 4) pick_element = (k % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
               else pick_element = (k == 1) ? 32'h8000_0000 : 32'h0;
            end
            MX_DOMINANT: begin
               if (r == k % 4)
                  pick_element = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(32'h8000,
                                                                                  32'h8_0000);
               else
                  pick_element = $urandom_range(0, 32'h8000) - 32'h4000;
            end
            default:      pick_element = $urandom;
         endcase
      end
   endfunction

   // one matrix; a duplicate-row matrix copies one of rows 0 to 2 into row 3
   task automatic queue_matrix(input matrix_kind_type kind, input logic start,
                               input logic drain);
      logic [ELEM_W-1:0] m[16];
      int                rep;
      begin
         for (int k = 0; k < 16; k++) m[k] = pick_element(kind, k);
         if (kind == MX_DUP_ROW) begin
            rep = $urandom_range(0, 2);
            for (int c = 0; c < 4; c++) m[12 + c] = m[rep * 4 + c];
         end
         if (kind != MX_EXTREME && $urandom_range(0, 9) == 0)
            m[$urandom_range(0, 15)] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         for (int k = 0; k < 16; k++)
            queue_word(m[k], (k == 0) ? start : 1'b0, (k == 0) ? drain : 1'b0);
      end
   endtask

   // input driver: advance to the next word once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid           <= 1'b0;
         req_element_value   <= '0;
         req_start_of_matrix <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 &&
                      (!pending_words[0].drain || expected_inverse.size() == 0)) begin
            req_element_value   <= pending_words[0].value;
            req_start_of_matrix <= pending_words[0].start;
            req_valid           <= 1'b1;
            void'(pending_words.pop_front());
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random gaps plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = ((results_seen / 64) % 3 == 2) ? 0 : pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   // accept input words and predict
   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         req_took = 1'b1;
         words_sent++;
         load_element(req_element_value, req_start_of_matrix);
      end
   end

   // check result words against the oldest expectation
   always @(posedge clock) begin
      inv_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_inverse.size() == 0) begin
            $error("unexpected result word, index %0d", rsp_element_index);
            error_count++;
         end else begin
            w = expected_inverse.pop_front();
            if (rsp_singular) singular_seen++;
            if (rsp_saturated) saturated_seen++;
            if (rsp_inverse_value !== w.value) begin
               $error("inverse_value: expected %h, got %h", w.value, rsp_inverse_value);
               error_count++;
            end
            if (rsp_element_index !== w.index) begin
               $error("element_index: expected %0d, got %0d", w.index, rsp_element_index);
               error_count++;
            end
            if (rsp_singular !== w.singular) begin
               $error("singular: expected %b, got %b", w.singular, rsp_singular);
               error_count++;
            end
            if (rsp_saturated !== w.saturated) begin
               $error("saturated: expected %b, got %b", w.saturated, rsp_saturated);
               error_count++;
            end
            if (rsp_last_element !== w.last) begin
               $error("last_element: expected %b, got %b", w.last, rsp_last_element);
               error_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int total;
      int r;
      reset               = 1'b1;
      held_count          = 0;
      error_count         = 0;
      words_sent          = 0;
      results_seen        = 0;
      singular_seen       = 0;
      saturated_seen      = 0;
      send_gap            = 0;
      stall_left          = 0;
      hold_left           = 0;
      long_hold_done      = 1'b0;
      req_took            = 1'b0;

      // directed: partial load dropped by a new start, then special matrices;
      // the identity waits until every earlier result is back
      for (int k = 0; k < 5; k++) queue_word($urandom, (k == 0), 1'b0);
      queue_matrix(MX_TINY_DIAG, 1'b1, 1'b0);
      queue_matrix(MX_ZERO, 1'b0, 1'b0);
      queue_matrix(MX_EXTREME, 1'b1, 1'b0);
      queue_matrix(MX_IDENTITY, 1'b0, 1'b1);

      // random: mostly whole matrices, some broken loads
      total = pending_words.size();
      while (total < 370) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            for (int k = $urandom_range(1, 15); k > 0; k--) queue_word($urandom, 1'b0, 1'b0);
            queue_matrix(MX_FULL_RANDOM, 1'b1, 1'b0);
         end else begin
            queue_matrix((r < 50) ? MX_DOMINANT : (r < 80) ? MX_FULL_RANDOM : MX_DUP_ROW,
                         $urandom_range(0, 3) != 0, total > 200 && total < 220);
         end
         total = pending_words.size();
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_inverse.size() > 0) @(posedge clock);
      repeat (1500) @(posedge clock);

      $display("Run covered %0d matrix words and %0d inverse words (%0d singular, %0d clipped).",
               words_sent, results_seen, singular_seen, saturated_seen);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Timeout: %0d inverse words still expected.", expected_inverse.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
